// ===== hdl/spcu_pkg.sv =====
package spcu_pkg;

    // Default sizes of the graph and of a group code.
    localparam int NODE_COUNT_DEF = 64;
    localparam int GROUP_BITS_DEF = 16;
    localparam int COUNT_W        = 6;

    // Operation codes.
    localparam logic [1:0] OP_SET    = 2'd0;
    localparam logic [1:0] OP_TOGGLE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Pair types.
    localparam logic [2:0] PT_COMMON  = 3'd0;
    localparam logic [2:0] PT_OUT_TWO = 3'd1;
    localparam logic [2:0] PT_IN_TWO  = 3'd2;
    localparam logic [2:0] PT_RECIP   = 3'd3;
    localparam logic [2:0] PT_OUT_SH  = 3'd4;
    localparam logic [2:0] PT_IN_SH   = 3'd5;

    // Configuration register indexes.
    localparam logic REG_PAIR_TYPE    = 1'b0;
    localparam logic REG_GROUP_FILTER = 1'b1;

    // Count increments, modulo 64.
    localparam logic [COUNT_W-1:0] CNT_PLUS_ONE  = 6'd1;
    localparam logic [COUNT_W-1:0] CNT_MINUS_ONE = 6'h3F;
    localparam logic [COUNT_W-1:0] CNT_PLUS_TWO  = 6'd2;
    localparam logic [COUNT_W-1:0] CNT_MINUS_TWO = 6'h3E;

    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  first_node;
        logic [5:0]  second_node;
        logic [15:0] attribute_code;
    } req_t;

    typedef struct packed {
        logic [5:0] pair_count;
        logic       edge_present;
        logic       status;
    } rsp_t;

    // Result of evaluating one walked node.
    typedef struct packed {
        logic               hit;
        logic               swap;
        logic               both;
        logic [COUNT_W-1:0] amount;
    } leg_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD_A,
        S_LOAD_B,
        S_LOAD_C,
        S_GK,
        S_EVAL,
        S_UPD1,
        S_UPD2,
        S_COMMIT
    } state_t;

    // True when the walk in this phase runs over the tail node's rows.
    function automatic logic base_is_tail(input logic [2:0] ptype, input logic phase);
        logic r;
        r = 1'b0;
        unique case (ptype)
            PT_COMMON:  r = ~phase;
            PT_OUT_TWO: r = phase;
            PT_IN_TWO:  r = phase;
            PT_RECIP:   r = ~phase;
            PT_OUT_SH:  r = 1'b0;
            PT_IN_SH:   r = 1'b1;
            default:    r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/spcu_leg.sv =====
module spcu_leg
    import spcu_pkg::*;
(
    input  logic [2:0] ptype,
    input  logic       phase,
    input  logic       ob,
    input  logic       ib,
    input  logic       k_is_other,
    input  logic       filter,
    input  logic       geq,
    input  logic       dec,
    output leg_t       leg
);

    logic bit_hit;
    logic two;

    // Decide whether the walked node closes a two-path and by how much it counts.
    always_comb
    begin
        bit_hit  = 1'b0;
        two      = 1'b0;
        leg.swap = 1'b0;
        leg.both = 1'b0;
        unique case (ptype)
            PT_COMMON:
            begin
                bit_hit  = ob | ib;
                two      = ob & ib;
                leg.both = 1'b1;
            end
            PT_OUT_TWO, PT_IN_TWO:
            begin
                bit_hit  = phase ? ib : ob;
                leg.swap = phase;
            end
            PT_RECIP:
            begin
                bit_hit  = ob & ib;
                leg.both = 1'b1;
            end
            PT_OUT_SH:
            begin
                bit_hit  = ib;
                leg.both = 1'b1;
            end
            PT_IN_SH:
            begin
                bit_hit  = ob;
                leg.both = 1'b1;
            end
            default:
            begin
                bit_hit = 1'b0;
            end
        endcase
        leg.hit = bit_hit & ~k_is_other & (~filter | geq);
        if (two)
            leg.amount = dec ? CNT_MINUS_TWO : CNT_PLUS_TWO;
        else
            leg.amount = dec ? CNT_MINUS_ONE : CNT_PLUS_ONE;
    end

endmodule

// ===== hdl/shared_partner_cache_update_core.sv =====
// Channel   Direction  Signals                       Moves
// in        input      in_valid, in_stall, in_data   one request (operation, nodes and attribute code)
// out       output     out_valid, out_stall, out_data one result per request
// cfg       input      write_enable, register_index,  pair type and group filter
//                      write_data
//
// After reset a clearing pass over all 2^(2*clog2(NODE_COUNT)) count addresses (4096 by default)
// zeroes the count store, the adjacency rows and the group codes; no request is taken meanwhile.
// A set, a read or a rejected toggle passes through S_IDLE, S_LOAD_A, S_LOAD_B, S_LOAD_C and S_COMMIT.
// A walking toggle also takes each node through S_GK and S_EVAL and, on a hit, S_UPD1 and maybe S_UPD2 on the single
// read-modify-write port of the count store, over one or two passes of NODE_COUNT nodes.
// The block takes a new request only while idle; a result waiting under out_stall
// holds the next request at its final step.
module shared_partner_cache_update_core
    import spcu_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int GROUP_BITS = GROUP_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  req_t       in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output rsp_t       out_data,
    input  logic       write_enable,
    input  logic       register_index,
    input  logic [2:0] write_data
);

    localparam int IW     = $clog2(NODE_COUNT);
    localparam int CW     = 2 * IW;
    localparam int RDEPTH = 1 << IW;
    localparam int CDEPTH = 1 << CW;

    // Memories.
    logic [NODE_COUNT-1:0] out_mem [RDEPTH];
    logic [NODE_COUNT-1:0] in_mem  [RDEPTH];
    logic [GROUP_BITS-1:0] grp_mem [RDEPTH];
    logic [COUNT_W-1:0]    cnt_mem [CDEPTH];

    logic [NODE_COUNT-1:0] out_rd, in_rd;
    logic [GROUP_BITS-1:0] grp_rd;
    logic [COUNT_W-1:0]    cnt_rd;

    // Sequencer state.
    state_t                state_reg, state_next;
    req_t                  req_reg, req_next;
    rsp_t                  rsp_reg, rsp_next;
    logic                  out_valid_reg, out_valid_next;
    logic [IW-1:0]         k_reg, k_next;
    logic                  phase_reg, phase_next;
    logic [CW-1:0]         clr_reg, clr_next;
    logic [NODE_COUNT-1:0] out_t_reg, out_t_next, in_t_reg, in_t_next;
    logic [NODE_COUNT-1:0] out_h_reg, out_h_next, in_h_reg, in_h_next;
    logic [GROUP_BITS-1:0] gt_reg, gt_next, gh_reg, gh_next;
    logic [COUNT_W-1:0]    cnt_reg, cnt_next;
    logic [2:0]            ptype_reg;
    logic                  filter_reg;

    // Memory port controls.
    logic [IW-1:0]         row_raddr, grp_raddr;
    logic [CW-1:0]         cnt_raddr, cnt_waddr;
    logic                  cnt_we, out_we, in_we, grp_we;
    logic [COUNT_W-1:0]    cnt_wdata;
    logic [IW-1:0]         out_waddr, in_waddr, grp_waddr;
    logic [NODE_COUNT-1:0] out_wdata, in_wdata;
    logic [GROUP_BITS-1:0] grp_wdata;

    // Decoded request.
    logic [IW-1:0] t_idx, h_idx;
    logic          a_ok, b_ok, in_range, tog_ok;
    logic          base_t, ob, ib, dec, two_phase, k_last;
    logic [IW-1:0] other;
    logic [CW-1:0] pair_addr, swap_addr, read_addr;
    leg_t          leg;

    assign t_idx     = IW'(req_reg.first_node);
    assign h_idx     = IW'(req_reg.second_node);
    assign a_ok      = 32'(req_reg.first_node) < 32'(NODE_COUNT);
    assign b_ok      = 32'(req_reg.second_node) < 32'(NODE_COUNT);
    assign in_range  = a_ok & b_ok;
    assign tog_ok    = (req_reg.operation == OP_TOGGLE) && in_range && (t_idx != h_idx);
    assign dec       = out_t_reg[h_idx];
    assign two_phase = ptype_reg <= PT_RECIP;
    assign k_last    = 32'(k_reg) == (NODE_COUNT - 1);

    // Pick the rows of the node the current phase walks around.
    assign base_t    = base_is_tail(ptype_reg, phase_reg);
    assign ob        = base_t ? out_t_reg[k_reg] : out_h_reg[k_reg];
    assign ib        = base_t ? in_t_reg[k_reg] : in_h_reg[k_reg];
    assign other     = base_t ? h_idx : t_idx;
    assign swap_addr = {k_reg, other};
    assign pair_addr = leg.swap ? swap_addr : {other, k_reg};
    assign read_addr = (ptype_reg == PT_IN_TWO) ? {h_idx, t_idx} : {t_idx, h_idx};

    spcu_leg u_leg (
        .ptype      (ptype_reg),
        .phase      (phase_reg),
        .ob         (ob),
        .ib         (ib),
        .k_is_other (k_reg == other),
        .filter     (filter_reg),
        .geq        ((base_t ? gt_reg : gh_reg) == grp_rd),
        .dec        (dec),
        .leg        (leg)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptype_reg  <= PT_COMMON;
            filter_reg <= 1'b0;
        end
        else if (write_enable)
        begin
            unique case (register_index)
                REG_PAIR_TYPE:    ptype_reg  <= write_data;
                REG_GROUP_FILTER: filter_reg <= write_data[0];
                default:          ptype_reg  <= ptype_reg;
            endcase
        end
    end

    // Memory reads and writes.
    always_ff @(posedge clk)
    begin
        out_rd <= out_mem[row_raddr];
        in_rd  <= in_mem[row_raddr];
        grp_rd <= grp_mem[grp_raddr];
        cnt_rd <= cnt_mem[cnt_raddr];
        if (out_we)
            out_mem[out_waddr] <= out_wdata;
        if (in_we)
            in_mem[in_waddr] <= in_wdata;
        if (grp_we)
            grp_mem[grp_waddr] <= grp_wdata;
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
            clr_reg       <= '0;
            k_reg         <= '0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            clr_reg       <= clr_next;
            k_reg         <= k_next;
            phase_reg     <= phase_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        rsp_reg   <= rsp_next;
        out_t_reg <= out_t_next;
        in_t_reg  <= in_t_next;
        out_h_reg <= out_h_next;
        in_h_reg  <= in_h_next;
        gt_reg    <= gt_next;
        gh_reg    <= gh_next;
        cnt_reg   <= cnt_next;
    end

    // Sequencer: next state, memory ports and result.
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        rsp_next       = rsp_reg;
        out_valid_next = out_valid_reg & out_stall;
        k_next         = k_reg;
        phase_next     = phase_reg;
        clr_next       = clr_reg;
        out_t_next     = out_t_reg;
        in_t_next      = in_t_reg;
        out_h_next     = out_h_reg;
        in_h_next      = in_h_reg;
        gt_next        = gt_reg;
        gh_next        = gh_reg;
        cnt_next       = cnt_reg;
        row_raddr      = t_idx;
        grp_raddr      = t_idx;
        cnt_raddr      = pair_addr;
        cnt_we         = 1'b0;
        cnt_waddr      = pair_addr;
        cnt_wdata      = cnt_rd + leg.amount;
        out_we         = 1'b0;
        out_waddr      = t_idx;
        out_wdata      = out_t_reg ^ (NODE_COUNT'(1) << h_idx);
        in_we          = 1'b0;
        in_waddr       = h_idx;
        in_wdata       = in_h_reg ^ (NODE_COUNT'(1) << t_idx);
        grp_we         = 1'b0;
        grp_waddr      = t_idx;
        grp_wdata      = GROUP_BITS'(req_reg.attribute_code);
        in_stall       = 1'b1;

        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = '0;
                out_we    = 1'b1;
                out_waddr = clr_reg[IW-1:0];
                out_wdata = '0;
                in_we     = 1'b1;
                in_waddr  = clr_reg[IW-1:0];
                in_wdata  = '0;
                grp_we    = 1'b1;
                grp_waddr = clr_reg[IW-1:0];
                grp_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (&clr_reg)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    req_next   = in_data;
                    state_next = S_LOAD_A;
                end
            end
            S_LOAD_A:
            begin
                cnt_raddr  = read_addr;
                grp_we     = (req_reg.operation == OP_SET) && a_ok;
                state_next = S_LOAD_B;
            end
            S_LOAD_B:
            begin
                out_t_next = out_rd;
                in_t_next  = in_rd;
                gt_next    = grp_rd;
                cnt_next   = cnt_rd;
                row_raddr  = h_idx;
                grp_raddr  = h_idx;
                state_next = S_LOAD_C;
            end
            S_LOAD_C:
            begin
                out_h_next = out_rd;
                in_h_next  = in_rd;
                gh_next    = grp_rd;
                k_next     = '0;
                phase_next = 1'b0;
                if (tog_ok && (ptype_reg <= PT_IN_SH) && (!filter_reg || gt_reg == grp_rd)
                    && (ptype_reg != PT_RECIP || out_rd[t_idx]))
                    state_next = S_GK;
                else
                    state_next = S_COMMIT;
            end
            S_GK:
            begin
                grp_raddr  = k_reg;
                state_next = S_EVAL;
            end
            S_EVAL, S_UPD1, S_UPD2:
            begin
                if (state_reg == S_UPD1)
                begin
                    cnt_we    = 1'b1;
                    cnt_raddr = swap_addr;
                end
                else if (state_reg == S_UPD2)
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = swap_addr;
                end
                if (state_reg == S_EVAL && leg.hit)
                    state_next = S_UPD1;
                else if (state_reg == S_UPD1 && leg.both)
                    state_next = S_UPD2;
                else if (!k_last)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_GK;
                end
                else if (!phase_reg && two_phase)
                begin
                    k_next     = '0;
                    phase_next = 1'b1;
                    state_next = S_GK;
                end
                else
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    out_we  = tog_ok;
                    in_we   = tog_ok;
                    rsp_next.pair_count   = (req_reg.operation == OP_READ && in_range
                                             && ptype_reg <= PT_IN_SH) ? cnt_reg : '0;
                    rsp_next.edge_present = in_range && (out_t_reg[h_idx] ^ tog_ok);
                    rsp_next.status       = (req_reg.operation == OP_TOGGLE) && !tog_ok;
                    out_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;

    // A rejected toggle never reports an edge or a count.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |-> !out_data.edge_present && out_data.pair_count == '0)
        else $error("rejected request carries an edge or count");

    // No request is taken during the clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> in_stall)
        else $error("request taken while clearing");

    // The walk only runs for valid toggles of a defined pair type.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_GK |-> tog_ok && ptype_reg <= PT_IN_SH)
        else $error("walk started for a request that changes no count");

    // A count update is always preceded by an evaluation or a first update.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPD1 |-> $past(state_reg) == S_EVAL)
        else $error("count update out of sequence");

endmodule
